// File: rtl/etok_pkg.sv
package etok_pkg;

    localparam int COUNT_BITS     = 32;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_IDX_BITS = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_NL      = 8'h0A;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_LPAREN  = 8'h28;
    localparam logic [7:0] CHAR_RPAREN  = 8'h29;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_CARET   = 8'h5E;

    typedef enum logic [3:0] {
        KIND_NUMBER = 4'd0,
        KIND_LPAREN = 4'd1,
        KIND_RPAREN = 4'd2,
        KIND_EXP    = 4'd3,
        KIND_MUL    = 4'd4,
        KIND_DIV    = 4'd5,
        KIND_REM    = 4'd6,
        KIND_PLUS   = 4'd7,
        KIND_MINUS  = 4'd8,
        KIND_ROOT   = 4'd9,
        KIND_EOF    = 4'd10,
        KIND_ERROR  = 4'd11
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_INVALID = 2'd1,
        ERR_PERIOD  = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_INT      = 3'd1,
        MODE_INT_DOT  = 3'd2,
        MODE_FRAC     = 3'd3,
        MODE_FRAC_DOT = 3'd4,
        MODE_DOT      = 3'd5
    } mode_t;

    // classified source byte
    typedef struct packed {
        logic       is_digit;
        logic [3:0] digit;
        logic       is_dot;
        logic       is_slash;
        logic       is_ws;
        logic       is_nl;
        logic       is_nul;
        logic       is_op;
        kind_t      op_kind;
        logic       emits;     // produces a result when lexed from idle
    } cls_t;

endpackage

// File: rtl/etok_front.sv
module etok_front
(
    input  logic [7:0]    ch,
    output etok_pkg::cls_t cls
);
    import etok_pkg::*;

    logic invalid;

    always_comb
    begin
        cls          = '0;
        cls.op_kind  = KIND_NUMBER;
        cls.is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
        cls.digit    = 4'(ch - CHAR_ZERO);
        cls.is_dot   = (ch == CHAR_DOT);
        cls.is_slash = (ch == CHAR_SLASH);
        cls.is_ws    = (ch == CHAR_SPACE) || (ch == CHAR_TAB) || (ch == CHAR_CR);
        cls.is_nl    = (ch == CHAR_NL);
        cls.is_nul   = (ch == CHAR_NUL);
        cls.is_op    = 1'b1;
        case (ch)
            CHAR_LPAREN:  cls.op_kind = KIND_LPAREN;
            CHAR_RPAREN:  cls.op_kind = KIND_RPAREN;
            CHAR_CARET:   cls.op_kind = KIND_EXP;
            CHAR_STAR:    cls.op_kind = KIND_MUL;
            CHAR_SLASH:   cls.op_kind = KIND_DIV;
            CHAR_PERCENT: cls.op_kind = KIND_REM;
            CHAR_PLUS:    cls.op_kind = KIND_PLUS;
            CHAR_MINUS:   cls.op_kind = KIND_MINUS;
            default:      cls.is_op   = 1'b0;
        endcase
        invalid   = !(cls.is_digit || cls.is_dot || cls.is_ws || cls.is_nl
                      || cls.is_nul || cls.is_op);
        cls.emits = cls.is_nul || cls.is_op || invalid;
    end

endmodule

// File: rtl/etok_queue.sv
module etok_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  etok_pkg::cls_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output etok_pkg::cls_t head
);
    import etok_pkg::*;

    cls_t                    mem [QUEUE_DEPTH];
    logic [QUEUE_IDX_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_IDX_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_IDX_BITS:0]   count_reg, count_next;

    assign full       = (count_reg == (QUEUE_IDX_BITS + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/etok_back.sv
module etok_back
#(
    parameter int MANTISSA_BITS   = 48,
    parameter int MAX_FRAC_DIGITS = 15,
    parameter int LINE_BITS       = 24,
    parameter int COLUMN_BITS     = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                head_valid,
    input  etok_pkg::cls_t                      head,
    output logic                                pop,
    output logic                                tok_valid,
    input  logic                                tok_stall,
    output logic [3:0]                          kind,
    output logic [1:0]                          error_code,
    output logic [MANTISSA_BITS-1:0]            mantissa,
    output logic [3:0]                          frac_digits,
    output logic                                overflow,
    output logic [LINE_BITS-1:0]                line,
    output logic [COLUMN_BITS-1:0]              column,
    output logic [etok_pkg::COUNT_BITS-1:0]     token_count,
    output logic                                last
);
    import etok_pkg::*;

    typedef struct packed {
        mode_t                    mode;
        logic [MANTISSA_BITS-1:0] acc_mant;
        logic [3:0]               acc_frac;
        logic                     acc_ovf;
        logic [LINE_BITS-1:0]     cur_line;
        logic [COLUMN_BITS-1:0]   cur_col;
        logic [LINE_BITS-1:0]     start_line;
        logic [COLUMN_BITS-1:0]   start_col;
        logic [COLUMN_BITS-1:0]   dot_col;
        logic [COUNT_BITS-1:0]    count;
    } st_t;

    typedef struct packed {
        kind_t                    kind;
        err_t                     err;
        logic [MANTISSA_BITS-1:0] mant;
        logic [3:0]               frac;
        logic                     ovf;
        logic [LINE_BITS-1:0]     line;
        logic [COLUMN_BITS-1:0]   col;
        logic [COUNT_BITS-1:0]    count;
        logic                     last;
    } res_t;

    typedef struct packed {
        st_t  st;
        logic emit;
        res_t res;
    } step_t;

    function automatic st_t restart_st();
        st_t s;
        s            = '0;
        s.mode       = MODE_IDLE;
        s.cur_line   = LINE_BITS'(1);
        s.cur_col    = COLUMN_BITS'(1);
        s.start_line = LINE_BITS'(1);
        s.start_col  = COLUMN_BITS'(1);
        s.dot_col    = COLUMN_BITS'(1);
        return s;
    endfunction

    function automatic logic [COLUMN_BITS-1:0] col_inc(logic [COLUMN_BITS-1:0] c);
        return (c != {COLUMN_BITS{1'b1}}) ? c + 1'b1 : c;
    endfunction

    function automatic logic [COUNT_BITS-1:0] cnt_inc(logic [COUNT_BITS-1:0] c);
        return (c != {COUNT_BITS{1'b1}}) ? c + 1'b1 : c;
    endfunction

    function automatic res_t tok(kind_t k, err_t e, logic [LINE_BITS-1:0] ln,
                                 logic [COLUMN_BITS-1:0] cl, logic [COUNT_BITS-1:0] cnt);
        res_t r;
        r       = '0;
        r.kind  = k;
        r.err   = e;
        r.line  = ln;
        r.col   = cl;
        r.count = cnt;
        r.last  = 1'b1;
        return r;
    endfunction

    // acc * 10 + d, saturating
    function automatic st_t push_digit(st_t s, logic [3:0] d);
        st_t                      r;
        logic [MANTISSA_BITS+3:0] w;
        r = s;
        w = ({4'b0, s.acc_mant} << 3) + ({4'b0, s.acc_mant} << 1)
            + {{MANTISSA_BITS{1'b0}}, d};
        if (|w[MANTISSA_BITS+3:MANTISSA_BITS])
        begin
            r.acc_mant = {MANTISSA_BITS{1'b1}};
            r.acc_ovf  = 1'b1;
        end
        else
        begin
            r.acc_mant = w[MANTISSA_BITS-1:0];
        end
        return r;
    endfunction

    function automatic st_t push_frac(st_t s, logic [3:0] d);
        st_t r;
        r = s;
        if (s.acc_frac < 4'(MAX_FRAC_DIGITS))
        begin
            r          = push_digit(s, d);
            r.acc_frac = s.acc_frac + 1'b1;
        end
        return r;
    endfunction

    function automatic step_t idle_path(st_t s, cls_t c);
        step_t r;
        r         = '0;
        r.st      = s;
        r.st.mode = MODE_IDLE;
        if (c.is_nul)
        begin
            r.emit = 1'b1;
            r.res  = tok(KIND_EOF, ERR_NONE, s.cur_line, s.cur_col, cnt_inc(s.count));
            r.st   = restart_st();
        end
        else if (c.is_ws)
        begin
            r.st.cur_col = col_inc(s.cur_col);
        end
        else if (c.is_nl)
        begin
            if (s.cur_line != {LINE_BITS{1'b1}})
            begin
                r.st.cur_line = s.cur_line + 1'b1;
            end
            r.st.cur_col = COLUMN_BITS'(1);
        end
        else if (c.is_dot)
        begin
            r.st.start_line = s.cur_line;
            r.st.start_col  = s.cur_col;
            r.st.dot_col    = s.cur_col;
            r.st.acc_mant   = '0;
            r.st.acc_frac   = '0;
            r.st.acc_ovf    = 1'b0;
            r.st.cur_col    = col_inc(s.cur_col);
            r.st.mode       = MODE_DOT;
        end
        else if (c.is_op)
        begin
            r.emit       = 1'b1;
            r.res        = tok(c.op_kind, ERR_NONE, s.cur_line, s.cur_col,
                               cnt_inc(s.count));
            r.st.count   = cnt_inc(s.count);
            r.st.cur_col = col_inc(s.cur_col);
        end
        else if (c.is_digit)
        begin
            r.st.start_line = s.cur_line;
            r.st.start_col  = s.cur_col;
            r.st.acc_mant   = {{(MANTISSA_BITS-4){1'b0}}, c.digit};
            r.st.acc_frac   = '0;
            r.st.acc_ovf    = 1'b0;
            r.st.cur_col    = col_inc(s.cur_col);
            r.st.mode       = MODE_INT;
        end
        else
        begin
            r.emit = 1'b1;
            r.res  = tok(KIND_ERROR, ERR_INVALID, s.cur_line, s.cur_col,
                         cnt_inc(s.count));
            r.st   = restart_st();
        end
        return r;
    endfunction

    st_t   st_reg, st_next;
    res_t  res_reg, res_next;
    logic  out_valid_reg, out_valid_next;
    step_t step;
    step_t ip;
    st_t   base;
    res_t  num_res;
    logic  consume;
    logic  go;

    assign go = head_valid && (!out_valid_reg || !tok_stall);

    always_comb
    begin
        step         = '0;
        step.st      = st_reg;
        consume      = 1'b1;
        base         = st_reg;
        base.mode    = MODE_IDLE;
        base.count   = cnt_inc(st_reg.count);
        num_res      = tok(KIND_NUMBER, ERR_NONE, st_reg.start_line, st_reg.start_col,
                           cnt_inc(st_reg.count));
        num_res.mant = st_reg.acc_mant;
        num_res.frac = st_reg.acc_frac;
        num_res.ovf  = st_reg.acc_ovf;
        ip           = idle_path(st_reg, head);
        case (st_reg.mode)
            MODE_INT, MODE_FRAC:
            begin
                if (head.is_digit)
                begin
                    step.st = (st_reg.mode == MODE_INT) ? push_digit(st_reg, head.digit)
                                                        : push_frac(st_reg, head.digit);
                    step.st.cur_col = col_inc(st_reg.cur_col);
                end
                else if (head.is_dot)
                begin
                    step.st.dot_col = st_reg.cur_col;
                    step.st.cur_col = col_inc(st_reg.cur_col);
                    step.st.mode    = (st_reg.mode == MODE_INT) ? MODE_INT_DOT
                                                                : MODE_FRAC_DOT;
                end
                else
                begin
                    step.emit     = 1'b1;
                    step.res      = num_res;
                    step.res.last = !head.emits;
                    if (head.emits)
                    begin
                        step.st = base;
                        consume = 1'b0;
                    end
                    else
                    begin
                        ip      = idle_path(base, head);
                        step.st = ip.st;
                    end
                end
            end
            MODE_INT_DOT, MODE_FRAC_DOT, MODE_DOT:
            begin
                if (head.is_slash)
                begin
                    step.emit = 1'b1;
                    if (st_reg.mode != MODE_DOT)
                    begin
                        step.res.last = 1'b0;
                        step.res      = num_res;
                        step.res.last = 1'b0;
                        step.st       = base;
                        step.st.mode  = MODE_DOT;
                        consume       = 1'b0;
                    end
                    else
                    begin
                        step.res        = tok(KIND_ROOT, ERR_NONE, st_reg.cur_line,
                                              st_reg.dot_col, cnt_inc(st_reg.count));
                        step.st         = base;
                        step.st.cur_col = col_inc(st_reg.cur_col);
                    end
                end
                else if (head.is_digit && (st_reg.mode != MODE_FRAC_DOT))
                begin
                    step.st         = push_frac(st_reg, head.digit);
                    step.st.cur_col = col_inc(st_reg.cur_col);
                    step.st.mode    = MODE_FRAC;
                end
                else
                begin
                    step.emit     = 1'b1;
                    step.res      = tok(KIND_ERROR, ERR_PERIOD, st_reg.cur_line,
                                        st_reg.dot_col, cnt_inc(st_reg.count));
                    step.res.last = !head.emits;
                    if (head.emits)
                    begin
                        step.st = restart_st();
                        consume = 1'b0;
                    end
                    else
                    begin
                        ip      = idle_path(restart_st(), head);
                        step.st = ip.st;
                    end
                end
            end
            default:
            begin
                step = ip;
            end
        endcase
    end

    always_comb
    begin
        st_next        = st_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && tok_stall;
        pop            = 1'b0;
        if (go)
        begin
            st_next = step.st;
            pop     = consume;
            if (step.emit)
            begin
                res_next       = step.res;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= restart_st();
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign tok_valid   = out_valid_reg;
    assign kind        = res_reg.kind;
    assign error_code  = res_reg.err;
    assign mantissa    = res_reg.mant;
    assign frac_digits = res_reg.frac;
    assign overflow    = res_reg.ovf;
    assign line        = res_reg.line;
    assign column      = res_reg.col;
    assign token_count = res_reg.count;
    assign last        = res_reg.last;

endmodule

// File: rtl/expression_tokenizer_top.sv
// Streaming lexer for arithmetic expressions: one source byte per transfer on ch (0 ends the
// source), tokens out with start line/column and a running count. A byte enters a
// four-entry queue and its tokens leave through a result register. One byte is consumed
// per cycle unless tok_stall holds a waiting result; the only other exceptions are a number
// ended by an operator, NUL or invalid byte, a number followed by "./", and a misplaced
// period followed by such a byte, which stay at the queue head for a second token because
// the single result register delivers one token per cycle. Results hold while tok_stall is high.
module expression_tokenizer_top
#(
    parameter int MANTISSA_BITS   = 48,
    parameter int MAX_FRAC_DIGITS = 15,
    parameter int LINE_BITS       = 24,
    parameter int COLUMN_BITS     = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [7:0]                      ch,
    input  logic                            ch_valid,
    output logic                            ch_stall,
    output logic                            tok_valid,
    input  logic                            tok_stall,
    output logic [3:0]                      kind,
    output logic [1:0]                      error_code,
    output logic [MANTISSA_BITS-1:0]        mantissa,
    output logic [3:0]                      frac_digits,
    output logic                            overflow,
    output logic [LINE_BITS-1:0]            line,
    output logic [COLUMN_BITS-1:0]          column,
    output logic [etok_pkg::COUNT_BITS-1:0] token_count,
    output logic                            last
);
    import etok_pkg::*;

    cls_t cls;
    cls_t head;
    logic full;
    logic head_valid;
    logic pop;

    assign ch_stall = full;

    etok_front u_front
    (
        .ch  (ch),
        .cls (cls)
    );

    etok_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (ch_valid && !full),
        .push_data  (cls),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    etok_back
    #(
        .MANTISSA_BITS   (MANTISSA_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
        .LINE_BITS       (LINE_BITS),
        .COLUMN_BITS     (COLUMN_BITS)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .tok_valid   (tok_valid),
        .tok_stall   (tok_stall),
        .kind        (kind),
        .error_code  (error_code),
        .mantissa    (mantissa),
        .frac_digits (frac_digits),
        .overflow    (overflow),
        .line        (line),
        .column      (column),
        .token_count (token_count),
        .last        (last)
    );

endmodule

// File: rtl/etok_checker.sv
module etok_checker
#(
    parameter int MANTISSA_BITS   = 48,
    parameter int MAX_FRAC_DIGITS = 15,
    parameter int LINE_BITS       = 24,
    parameter int COLUMN_BITS     = 16
)
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            tok_valid,
    input logic                            tok_stall,
    input logic [3:0]                      kind,
    input logic [1:0]                      error_code,
    input logic [MANTISSA_BITS-1:0]        mantissa,
    input logic [3:0]                      frac_digits,
    input logic                            overflow,
    input logic [LINE_BITS-1:0]            line,
    input logic [COLUMN_BITS-1:0]          column,
    input logic [etok_pkg::COUNT_BITS-1:0] token_count,
    input logic                            last
);
    import etok_pkg::*;

    // stalled token holds
    a_tok_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_stall |=> tok_valid && $stable(kind) && $stable(token_count)
                                   && $stable(line) && $stable(column) && $stable(last))
        else $error("stalled token changed");

    // only numbers carry a value
    a_num_fields: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && (kind != KIND_NUMBER) |-> (mantissa == '0) && (frac_digits == '0)
                                               && !overflow)
        else $error("value fields set on a non-number token");

    // error code present exactly on error tokens
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE)))
        else $error("error code does not match token kind");

    // positions start at one and every token is counted
    a_pos: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> (token_count != '0) && (line != '0) && (column != '0))
        else $error("zero position or count");

    // fraction count bounded
    a_frac: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> (frac_digits <= 4'(MAX_FRAC_DIGITS)))
        else $error("too many fraction digits");

endmodule

bind expression_tokenizer_top etok_checker
#(
    .MANTISSA_BITS   (MANTISSA_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
    .LINE_BITS       (LINE_BITS),
    .COLUMN_BITS     (COLUMN_BITS)
)
u_etok_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .tok_valid   (tok_valid),
    .tok_stall   (tok_stall),
    .kind        (kind),
    .error_code  (error_code),
    .mantissa    (mantissa),
    .frac_digits (frac_digits),
    .overflow    (overflow),
    .line        (line),
    .column      (column),
    .token_count (token_count),
    .last        (last)
);

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import etok_pkg::*;

    localparam int MANT_W      = 48;
    localparam int MAX_FRAC    = 15;
    localparam int LINE_W      = 24;
    localparam int COL_W       = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_LEN    = 400;
    localparam int PHASE_ITEMS = 250;

    localparam logic [MANT_W-1:0] MANT_TOP = '1;

    typedef struct packed {
        kind_t              kind;
        err_t               err;
        logic [MANT_W-1:0]  mant;
        logic [3:0]         frac;
        logic               ovf;
        logic [LINE_W-1:0]  line;
        logic [COL_W-1:0]   col;
        logic [31:0]        count;
        logic               last;
    } token_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic        typed;
        kind_t       kind;
        err_t        err;
        int          col;
        int          count;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic [7:0]          ch = '0;
    logic                ch_valid = 1'b0;
    logic                ch_stall;
    logic                tok_valid;
    logic                tok_stall = 1'b0;
    logic [3:0]          tok_kind;
    logic [1:0]          tok_err;
    logic [MANT_W-1:0]   tok_mant;
    logic [3:0]          tok_frac;
    logic                tok_ovf;
    logic [LINE_W-1:0]   tok_line;
    logic [COL_W-1:0]    tok_col;
    logic [31:0]         tok_count;
    logic                tok_last;

    // lexer state of the predictor
    mode_t               lx_mode;
    logic [MANT_W-1:0]   lx_mant;
    logic [3:0]          lx_frac;
    logic                lx_ovf;
    logic [LINE_W-1:0]   lx_line;
    logic [COL_W-1:0]    lx_col;
    logic [LINE_W-1:0]   lx_sline;
    logic [COL_W-1:0]    lx_scol;
    logic [COL_W-1:0]    lx_dot;
    logic [31:0]         lx_count;

    token_t              step_tokens[$];
    token_t              pending_tokens[$];
    logic [7:0]          src_bytes[$];
    dir_row_t            dir_table[26];

    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    logic                long_hold = 1'b0;
    int                  hold_cycles = 0;
    int                  cycle_count = 0;
    int                  fail_count = 0;
    int                  bytes_sent = 0;
    int                  items_sent = 0;
    int                  tokens_checked = 0;
    int                  error_tokens = 0;
    int                  sat_numbers = 0;

    expression_tokenizer_top #(
        .MANTISSA_BITS   (MANT_W),
        .MAX_FRAC_DIGITS (MAX_FRAC),
        .LINE_BITS       (LINE_W),
        .COLUMN_BITS     (COL_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .ch          (ch),
        .ch_valid    (ch_valid),
        .ch_stall    (ch_stall),
        .tok_valid   (tok_valid),
        .tok_stall   (tok_stall),
        .kind        (tok_kind),
        .error_code  (tok_err),
        .mantissa    (tok_mant),
        .frac_digits (tok_frac),
        .overflow    (tok_ovf),
        .line        (tok_line),
        .column      (tok_col),
        .token_count (tok_count),
        .last        (tok_last)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d tokens pending",
                     cycle_count, pending_tokens.size());
            $display("expression_tokenizer_top: mismatch");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_stall   <= 1'b0;
            hold_cycles <= 0;
        end
        else if (long_hold && hold_cycles < HOLD_LEN)
        begin
            tok_stall   <= 1'b1;
            hold_cycles <= hold_cycles + 1;
        end
        else
        begin
            tok_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    task automatic report_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= 50)
                $display("%0t token %0d: %s got %0h want %0h",
                         $time, tokens_checked, name, got, want);
        end
    endtask

    always @(posedge clk)
    begin
        token_t want;
        if (rst_n && tok_valid && !tok_stall)
        begin
            if (pending_tokens.size() == 0)
            begin
                report_field("transfer with nothing pending", 64'd1, 64'd0);
            end
            else
            begin
                want = pending_tokens.pop_front();
                report_field("kind", 64'(tok_kind), 64'(want.kind));
                report_field("error_code", 64'(tok_err), 64'(want.err));
                report_field("mantissa", 64'(tok_mant), 64'(want.mant));
                report_field("frac_digits", 64'(tok_frac), 64'(want.frac));
                report_field("overflow", 64'(tok_ovf), 64'(want.ovf));
                report_field("line", 64'(tok_line), 64'(want.line));
                report_field("column", 64'(tok_col), 64'(want.col));
                report_field("token_count", 64'(tok_count), 64'(want.count));
                report_field("last", 64'(tok_last), 64'(want.last));
                if (want.kind == KIND_ERROR)
                    error_tokens++;
                if (want.ovf)
                    sat_numbers++;
            end
            tokens_checked++;
        end
    end

    function automatic bit is_digit_char(logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function automatic void col_step();
        if (lx_col != '1)
            lx_col++;
    endfunction

    function automatic void restart_lexer();
        lx_mode  = MODE_IDLE;
        lx_mant  = '0;
        lx_frac  = '0;
        lx_ovf   = 1'b0;
        lx_line  = LINE_W'(1);
        lx_col   = COL_W'(1);
        lx_sline = LINE_W'(1);
        lx_scol  = COL_W'(1);
        lx_dot   = COL_W'(1);
        lx_count = '0;
    endfunction

    function automatic void push_token(kind_t k, err_t e, logic [MANT_W-1:0] m,
                                       logic [3:0] f, logic o,
                                       logic [LINE_W-1:0] ln, logic [COL_W-1:0] cl);
        token_t t;
        if (lx_count != '1)
            lx_count++;
        t.kind  = k;
        t.err   = e;
        t.mant  = m;
        t.frac  = f;
        t.ovf   = o;
        t.line  = ln;
        t.col   = cl;
        t.count = lx_count;
        t.last  = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void emit_number();
        push_token(KIND_NUMBER, ERR_NONE, lx_mant, lx_frac, lx_ovf, lx_sline, lx_scol);
        lx_mode = MODE_IDLE;
    endfunction

    function automatic void add_digit(logic [3:0] d);
        logic [63:0] top;
        top = {{(64 - MANT_W){1'b0}}, MANT_TOP};
        if ({{(64 - MANT_W){1'b0}}, lx_mant} > (top - 64'(d)) / 64'd10)
        begin
            lx_mant = MANT_TOP;
            lx_ovf  = 1'b1;
        end
        else
        begin
            lx_mant = lx_mant * MANT_W'(10) + MANT_W'(d);
        end
    endfunction

    function automatic void add_frac_digit(logic [3:0] d);
        if (lx_frac < MAX_FRAC)
        begin
            add_digit(d);
            lx_frac++;
        end
    endfunction

    function automatic void lex_from_idle(logic [7:0] c);
        kind_t k;
        bit    op;
        k = KIND_NUMBER;
        op = 1'b1;
        lx_mode = MODE_IDLE;
        case (c)
            CHAR_NUL:
            begin
                push_token(KIND_EOF, ERR_NONE, '0, '0, 1'b0, lx_line, lx_col);
                restart_lexer();
                op = 1'b0;
            end
            CHAR_SPACE, CHAR_TAB, CHAR_CR:
            begin
                col_step();
                op = 1'b0;
            end
            CHAR_NL:
            begin
                if (lx_line != '1)
                    lx_line++;
                lx_col = COL_W'(1);
                op = 1'b0;
            end
            CHAR_DOT:
            begin
                lx_sline = lx_line;
                lx_scol  = lx_col;
                lx_dot   = lx_col;
                lx_mant  = '0;
                lx_frac  = '0;
                lx_ovf   = 1'b0;
                col_step();
                lx_mode  = MODE_DOT;
                op = 1'b0;
            end
            CHAR_LPAREN:  k = KIND_LPAREN;
            CHAR_RPAREN:  k = KIND_RPAREN;
            CHAR_CARET:   k = KIND_EXP;
            CHAR_STAR:    k = KIND_MUL;
            CHAR_SLASH:   k = KIND_DIV;
            CHAR_PERCENT: k = KIND_REM;
            CHAR_PLUS:    k = KIND_PLUS;
            CHAR_MINUS:   k = KIND_MINUS;
            default:
            begin
                op = 1'b0;
                if (is_digit_char(c))
                begin
                    lx_sline = lx_line;
                    lx_scol  = lx_col;
                    lx_mant  = '0;
                    lx_frac  = '0;
                    lx_ovf   = 1'b0;
                    add_digit(4'(c - CHAR_ZERO));
                    col_step();
                    lx_mode  = MODE_INT;
                end
                else
                begin
                    push_token(KIND_ERROR, ERR_INVALID, '0, '0, 1'b0, lx_line, lx_col);
                    restart_lexer();
                end
            end
        endcase
        if (op)
        begin
            push_token(k, ERR_NONE, '0, '0, 1'b0, lx_line, lx_col);
            col_step();
        end
    endfunction

    function automatic void lex_byte(logic [7:0] c);
        token_t t;
        step_tokens.delete();
        case (lx_mode)
            MODE_INT, MODE_FRAC:
            begin
                if (is_digit_char(c))
                begin
                    if (lx_mode == MODE_INT)
                        add_digit(4'(c - CHAR_ZERO));
                    else
                        add_frac_digit(4'(c - CHAR_ZERO));
                    col_step();
                end
                else if (c == CHAR_DOT)
                begin
                    lx_dot = lx_col;
                    col_step();
                    lx_mode = (lx_mode == MODE_INT) ? MODE_INT_DOT : MODE_FRAC_DOT;
                end
                else
                begin
                    emit_number();
                    lex_from_idle(c);
                end
            end
            MODE_INT_DOT, MODE_FRAC_DOT, MODE_DOT:
            begin
                if (c == CHAR_SLASH)
                begin
                    if (lx_mode != MODE_DOT)
                        emit_number();
                    push_token(KIND_ROOT, ERR_NONE, '0, '0, 1'b0, lx_line, lx_dot);
                    col_step();
                    lx_mode = MODE_IDLE;
                end
                else if (is_digit_char(c) && lx_mode != MODE_FRAC_DOT)
                begin
                    add_frac_digit(4'(c - CHAR_ZERO));
                    col_step();
                    lx_mode = MODE_FRAC;
                end
                else
                begin
                    push_token(KIND_ERROR, ERR_PERIOD, '0, '0, 1'b0, lx_line, lx_dot);
                    restart_lexer();
                    lex_from_idle(c);
                end
            end
            default: lex_from_idle(c);
        endcase
        if (step_tokens.size() > 0)
        begin
            t = step_tokens[step_tokens.size() - 1];
            t.last = 1'b1;
            step_tokens[step_tokens.size() - 1] = t;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input token_t want = '0);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            ch_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        ch       <= b;
        ch_valid <= 1'b1;
        @(posedge clk);
        while (ch_stall)
            @(posedge clk);
        lex_byte(b);
        if (typed)
            pending_tokens.push_back(want);
        else
            foreach (step_tokens[i])
                pending_tokens.push_back(step_tokens[i]);
        bytes_sent++;
        if (b != CHAR_SPACE && b != CHAR_TAB && b != CHAR_CR && b != CHAR_NL)
            items_sent++;
    endtask

    task automatic gen_number();
        int shape;
        int int_len;
        int frac_len;
        shape    = $urandom_range(0, 2);
        int_len  = ($urandom_range(0, 15) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 4);
        frac_len = ($urandom_range(0, 15) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 4);
        if (shape != 2)
            repeat (int_len)
                src_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        if (shape != 0)
        begin
            src_bytes.push_back(CHAR_DOT);
            repeat (frac_len)
                src_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    // one source: mostly well formed, with some noise and broken periods
    task automatic gen_source();
        int         n_tok;
        int         pick;
        logic [7:0] c;
        n_tok = $urandom_range(1, 12);
        for (int i = 0; i < n_tok; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                gen_number();
            end
            else if (pick < 78)
            begin
                case ($urandom_range(0, 7))
                    0: c = CHAR_LPAREN;
                    1: c = CHAR_RPAREN;
                    2: c = CHAR_CARET;
                    3: c = CHAR_STAR;
                    4: c = CHAR_SLASH;
                    5: c = CHAR_PERCENT;
                    6: c = CHAR_PLUS;
                    default: c = CHAR_MINUS;
                endcase
                src_bytes.push_back(c);
            end
            else if (pick < 86)
            begin
                if ($urandom_range(0, 1))
                    gen_number();
                src_bytes.push_back(CHAR_DOT);
                src_bytes.push_back(CHAR_SLASH);
            end
            else if (pick < 93)
            begin
                src_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                if ($urandom_range(0, 1))
                    gen_number();
                src_bytes.push_back(CHAR_DOT);
                do
                    c = 8'($urandom_range(0, 255));
                while (is_digit_char(c) || c == CHAR_SLASH);
                src_bytes.push_back(c);
            end
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: c = CHAR_SPACE;
                    1: c = CHAR_TAB;
                    2: c = CHAR_CR;
                    default: c = CHAR_NL;
                endcase
                src_bytes.push_back(c);
            end
        end
        if ($urandom_range(0, 9) != 0)
            src_bytes.push_back(CHAR_NUL);
    endtask

    task automatic run_random(int n_items);
        int goal;
        goal = bytes_sent + n_items;
        while (bytes_sent < goal)
        begin
            gen_source();
            while (src_bytes.size() > 0)
                send_byte(src_bytes.pop_front());
        end
    endtask

    initial
    begin
        token_t t;
        restart_lexer();
        dir_table = '{
            '{CHAR_LPAREN,  1'b1, KIND_LPAREN, ERR_NONE,    1, 1},
            '{CHAR_RPAREN,  1'b1, KIND_RPAREN, ERR_NONE,    2, 2},
            '{CHAR_CARET,   1'b1, KIND_EXP,    ERR_NONE,    3, 3},
            '{CHAR_STAR,    1'b1, KIND_MUL,    ERR_NONE,    4, 4},
            '{CHAR_SLASH,   1'b1, KIND_DIV,    ERR_NONE,    5, 5},
            '{CHAR_PERCENT, 1'b1, KIND_REM,    ERR_NONE,    6, 6},
            '{CHAR_PLUS,    1'b1, KIND_PLUS,   ERR_NONE,    7, 7},
            '{CHAR_MINUS,   1'b1, KIND_MINUS,  ERR_NONE,    8, 8},
            '{CHAR_NUL,     1'b1, KIND_EOF,    ERR_NONE,    9, 9},
            '{8'hFF,        1'b1, KIND_ERROR,  ERR_INVALID, 1, 1},
            '{CHAR_DOT,     1'b0, KIND_NUMBER, ERR_NONE,    0, 0},
            '{CHAR_SPACE,   1'b1, KIND_ERROR,  ERR_PERIOD,  1, 1},
            '{CHAR_TAB,     1'b0, KIND_NUMBER, ERR_NONE,    0, 0},
            '{CHAR_NL,      1'b0, KIND_NUMBER, ERR_NONE,    0, 0},
            '{CHAR_ZERO + 8'd1, 1'b0, KIND_NUMBER, ERR_NONE, 0, 0},
            '{CHAR_ZERO + 8'd2, 1'b0, KIND_NUMBER, ERR_NONE, 0, 0},
            '{CHAR_DOT,     1'b0, KIND_NUMBER, ERR_NONE,    0, 0},
            '{CHAR_SLASH,   1'b0, KIND_NUMBER, ERR_NONE,    0, 0},
            '{CHAR_DOT,     1'b0, KIND_NUMBER, ERR_NONE,    0, 0},
            '{CHAR_ZERO + 8'd5, 1'b0, KIND_NUMBER, ERR_NONE, 0, 0},
            '{CHAR_PERCENT, 1'b0, KIND_NUMBER, ERR_NONE,    0, 0},
            '{CHAR_ZERO + 8'd7, 1'b0, KIND_NUMBER, ERR_NONE, 0, 0},
            '{CHAR_DOT,     1'b0, KIND_NUMBER, ERR_NONE,    0, 0},
            '{CHAR_PLUS,    1'b0, KIND_NUMBER, ERR_NONE,    0, 0},
            '{CHAR_ZERO + 8'd9, 1'b0, KIND_NUMBER, ERR_NONE, 0, 0},
            '{CHAR_NUL,     1'b0, KIND_NUMBER, ERR_NONE,    0, 0}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
        begin
            t       = '0;
            t.kind  = dir_table[i].kind;
            t.err   = dir_table[i].err;
            t.line  = LINE_W'(1);
            t.col   = COL_W'(dir_table[i].col);
            t.count = dir_table[i].count;
            t.last  = 1'b1;
            send_byte(dir_table[i].ch, dir_table[i].typed, t);
        end

        run_random(PHASE_ITEMS);

        // long receiver hold while the sender keeps offering
        long_hold <= 1'b1;
        run_random(150);
        long_hold <= 1'b0;

        send_idle_pct = 66;
        run_random(PHASE_ITEMS);

        send_idle_pct  = 0;
        recv_stall_pct = 66;
        run_random(PHASE_ITEMS);

        send_idle_pct  = 26;
        recv_stall_pct = 26;
        run_random(PHASE_ITEMS);
        send_byte(CHAR_NUL);
        ch_valid <= 1'b0;

        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d bytes (%0d non-blank), checked %0d tokens", bytes_sent,
                 items_sent, tokens_checked);
        $display("%0d error results, %0d saturated numbers, long output hold and idle mixes",
                 error_tokens, sat_numbers);
        if (fail_count == 0)
        begin
            $display("expression_tokenizer_top: match");
        end
        else
        begin
            $display("%0d field mismatches", fail_count);
            $display("expression_tokenizer_top: mismatch");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/etok_pkg.sv
rtl/etok_front.sv
rtl/etok_queue.sv
rtl/etok_back.sv
rtl/expression_tokenizer_top.sv
rtl/etok_checker.sv
bench/tb_top.sv
